// File: design/hcx_pkg.sv
package hcx_pkg;

  localparam int BLOCK_BYTES = 32;
  localparam int POS_W       = 6;
  localparam int ROUNDS      = 64;
  localparam int ROUND_W     = 6;
  localparam int KEY_WORDS   = 4;
  localparam int CFG_IDX_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 8'd3;

  localparam logic [POS_W-1:0] POS_EXHAUSTED = 6'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_FIN
  } core_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  localparam logic [31:0] SHA_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Padding words for a single 32-byte message.
  localparam logic [31:0] PAD_FIRST = 32'h80000000;
  localparam logic [31:0] PAD_LEN   = 32'h00000100;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// File: design/hash_chain_keystream_xor_core.sv
// Byte stream cipher whose keystream is a SHA-256 hash chain.
// Configuration: cfg_valid/cfg_ready write the four 64-bit key words by
// cfg_index (0..3, other indexes are ignored); a new key is used from the
// next request that has msg_start set.
// Input channel: each request carries one byte plus msg_start and msg_last.
// msg_start restarts the keystream at SHA-256 of the key; otherwise each
// new 32-byte block is SHA-256 of the block before it.
// Output channel: one result per request, the byte XORed with the next
// keystream byte and a copy of msg_last.
// Sequence: a request accepted while the current block still has bytes goes
// straight to the emit state; otherwise the block is hashed first (64 rounds
// of the single round unit, then the digest is loaded) before the emit state.
// A new request is taken only once the previous byte has been emitted.
// A result waiting in the output register does not stop the next request
// from being accepted; the block only holds in the emit state until the
// register is free. Reset clears the key, the block and marks it used up.
module hash_chain_keystream_xor_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hcx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_msg_start,
  input  logic                             in_msg_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_last
);

  hcx_pkg::ctl_state_t state_r, state_nxt;
  logic [63:0] key_r [hcx_pkg::KEY_WORDS];
  logic [255:0] block_r, block_nxt;
  logic [hcx_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0] data_r, data_nxt;
  logic last_r, last_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic out_last_r, out_last_nxt;

  logic in_acc;
  logic need_hash;
  logic core_start;
  logic [255:0] core_src;
  logic [255:0] digest;
  logic [255:0] block_shifted;
  hcx_pkg::core_status_t core_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == hcx_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  // Position 32 means the current block is used up.
  assign need_hash  = in_msg_start || pos_r[hcx_pkg::POS_W-1];
  assign core_start = in_acc && need_hash;
  assign core_src   = in_msg_start ? {key_r[0], key_r[1], key_r[2], key_r[3]} : block_r;

  hcx_sha_core u_sha (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (core_start),
    .src    (core_src),
    .status (core_status),
    .digest (digest)
  );

  // Byte p of the block sits in bits 255-8p down to 248-8p.
  assign block_shifted = block_r >> {~pos_r[hcx_pkg::POS_W-2:0], 3'b000};

  always_comb begin
    state_nxt     = state_r;
    block_nxt     = block_r;
    pos_nxt       = pos_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      hcx_pkg::ST_IDLE: begin
        if (in_acc) begin
          data_nxt  = in_data_byte;
          last_nxt  = in_msg_last;
          state_nxt = need_hash ? hcx_pkg::ST_HASH : hcx_pkg::ST_EMIT;
        end
      end
      hcx_pkg::ST_HASH: begin
        if (core_status.done) begin
          block_nxt = digest;
          pos_nxt   = '0;
          state_nxt = hcx_pkg::ST_EMIT;
        end
      end
      hcx_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_r ^ block_shifted[7:0];
          out_last_nxt  = last_r;
          pos_nxt       = pos_r + 1'b1;
          state_nxt     = hcx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hcx_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcx_pkg::ST_IDLE;
      block_r     <= '0;
      pos_r       <= hcx_pkg::POS_EXHAUSTED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      block_r     <= block_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hcx_pkg::KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hcx_pkg::REG_KEY_WORD0: key_r[0] <= cfg_data;
        hcx_pkg::REG_KEY_WORD1: key_r[1] <= cfg_data;
        hcx_pkg::REG_KEY_WORD2: key_r[2] <= cfg_data;
        hcx_pkg::REG_KEY_WORD3: key_r[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    last_r     <= last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// File: design/hcx_sha_core.sv
module hcx_sha_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [255:0]            src,
  output hcx_pkg::core_status_t   status,
  output logic [255:0]            digest
);

  hcx_pkg::core_state_t state_r, state_nxt;
  logic [hcx_pkg::ROUND_W-1:0] round_r, round_nxt;
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  // One compression round per cycle; the message schedule is a 16-word
  // sliding window whose oldest word feeds the current round.
  always_comb begin
    t1 = v_r[7] + hcx_pkg::big_sigma1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + hcx_pkg::SHA_K[round_r] + w_r[0];
    t2 = hcx_pkg::big_sigma0(v_r[0])
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = w_r[0] + hcx_pkg::small_sigma0(w_r[1]) + w_r[9] + hcx_pkg::small_sigma1(w_r[14]);
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    w_nxt     = w_r;
    v_nxt     = v_r;
    case (state_r)
      hcx_pkg::CORE_IDLE: begin
        if (start) begin
          for (int i = 0; i < 8; i++) begin
            w_nxt[i] = src[255 - 32*i -: 32];
            v_nxt[i] = hcx_pkg::SHA_IV[i];
          end
          w_nxt[8] = hcx_pkg::PAD_FIRST;
          for (int i = 9; i < 15; i++) begin
            w_nxt[i] = 32'd0;
          end
          w_nxt[15] = hcx_pkg::PAD_LEN;
          round_nxt = '0;
          state_nxt = hcx_pkg::CORE_RUN;
        end
      end
      hcx_pkg::CORE_RUN: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        round_nxt = round_r + 1'b1;
        if (round_r == hcx_pkg::ROUND_W'(hcx_pkg::ROUNDS - 1)) begin
          state_nxt = hcx_pkg::CORE_FIN;
        end
      end
      hcx_pkg::CORE_FIN: begin
        state_nxt = hcx_pkg::CORE_IDLE;
      end
      default: begin
        state_nxt = hcx_pkg::CORE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hcx_pkg::CORE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    round_r <= round_nxt;
    w_r     <= w_nxt;
    v_r     <= v_nxt;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digest[255 - 32*i -: 32] = hcx_pkg::SHA_IV[i] + v_r[i];
    end
  end

  assign status.busy = (state_r != hcx_pkg::CORE_IDLE);
  assign status.done = (state_r == hcx_pkg::CORE_FIN);

endmodule

// File: tb/hcx_keystream_checker.sv
`timescale 1ns / 1ps

module hcx_keystream_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [hcx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_msg_start,
  input  logic                          in_msg_last,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [7:0]                    out_byte,
  input  logic                          out_last,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_result_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] HASH_INIT =
    256'h6a09e667_bb67ae85_3c6ef372_a54ff53a_510e527f_9b05688c_1f83d9ab_5be0cd19;

  logic [63:0]    key_word [hcx_pkg::KEY_WORDS];
  logic [255:0]   chain_block;
  int             chain_pos;
  cipher_result_t expected_cipher_q [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Digest of exactly 32 bytes, first byte in the top bits, padded as one block.
  function automatic logic [255:0] sha256_32byte(input logic [255:0] msg);
    logic [31:0]  w [64];
    logic [31:0]  a, b, c, d, e, f, g, h;
    logic [31:0]  t1, t2;
    logic [255:0] work;
    logic [255:0] digest;
    for (int i = 0; i < 8; i++) w[i] = msg[255 - 32*i -: 32];
    w[8] = 32'h8000_0000;
    for (int i = 9; i < 15; i++) w[i] = '0;
    w[15] = 32'd256;
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    {a, b, c, d, e, f, g, h} = HASH_INIT;
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[i] + w[i];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    work = {a, b, c, d, e, f, g, h};
    for (int i = 0; i < 8; i++) begin
      digest[255 - 32*i -: 32] = work[255 - 32*i -: 32] + HASH_INIT[255 - 32*i -: 32];
    end
    return digest;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cipher_result_t want;
    logic [7:0]     ks;
    if (!rst_n) begin
      for (int i = 0; i < hcx_pkg::KEY_WORDS; i++) key_word[i] = '0;
      chain_block = '0;
      chain_pos = hcx_pkg::BLOCK_BYTES;
      expected_cipher_q.delete();
      pending = 0;
    end else begin
      // Writes to indexes past the key words are dropped.
      if (cfg_valid && cfg_ready && cfg_index < hcx_pkg::KEY_WORDS)
        key_word[cfg_index[1:0]] = cfg_data;
      if (in_valid && in_ready) begin
        if (in_msg_start) begin
          chain_block = sha256_32byte({key_word[0], key_word[1], key_word[2], key_word[3]});
          chain_pos = 0;
        end else if (chain_pos >= hcx_pkg::BLOCK_BYTES) begin
          chain_block = sha256_32byte(chain_block);
          chain_pos = 0;
        end
        ks = chain_block[255 - 8*chain_pos -: 8];
        chain_pos++;
        want.data = in_data_byte ^ ks;
        want.last = in_msg_last;
        expected_cipher_q.insert(expected_cipher_q.size(), want);
      end
      if (out_valid && out_ready) begin
        if (expected_cipher_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h last %0b", out_byte, out_last));
        end else begin
          want = expected_cipher_q.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
          if (out_last !== want.last)
            report_mismatch($sformatf("out_last %0b, expected %0b", out_last, want.last));
        end
      end
      pending = expected_cipher_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ITEM_TARGET   = 850;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 80;

  localparam logic [hcx_pkg::CFG_IDX_W-1:0] KEY_REGS [hcx_pkg::KEY_WORDS] = '{
    hcx_pkg::REG_KEY_WORD0, hcx_pkg::REG_KEY_WORD1,
    hcx_pkg::REG_KEY_WORD2, hcx_pkg::REG_KEY_WORD3
  };
  localparam logic [hcx_pkg::CFG_IDX_W-1:0] CFG_IDX_FIRST_UNUSED =
    hcx_pkg::CFG_IDX_W'(hcx_pkg::KEY_WORDS);
  localparam logic [hcx_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [hcx_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                   cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    in_data_byte;
  logic                          in_msg_start;
  logic                          in_msg_last;
  logic                          out_valid;
  logic                          out_ready;
  logic [7:0]                    out_byte;
  logic                          out_last;

  int fail_count;
  int pending;
  int sent_bytes = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 74;
  bit hold_request = 1'b0;

  hash_chain_keystream_xor_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_msg_start (in_msg_start),
    .in_msg_last  (in_msg_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  hcx_keystream_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_msg_start (in_msg_start),
    .in_msg_last  (in_msg_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, or one long hold-off when the stimulus asks for it.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic start, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_msg_start <= start;
    in_msg_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [hcx_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_key(input logic [255:0] k);
    for (int j = 0; j < hcx_pkg::KEY_WORDS; j++) write_cfg(KEY_REGS[j], k[255 - 64*j -: 64]);
  endtask

  task automatic random_config();
    int          n;
    int          pick;
    logic [63:0] value;
    drain_results();
    n = $urandom_range(hcx_pkg::KEY_WORDS, 1);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(9);
      if (pick == 0) value = '0;
      else if (pick == 1) value = '1;
      else value = {$urandom(), $urandom()};
      write_cfg(KEY_REGS[$urandom_range(hcx_pkg::KEY_WORDS - 1)], value);
    end
    if ($urandom_range(4) == 0)
      write_cfg(hcx_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_LAST, CFG_IDX_FIRST_UNUSED)),
                {$urandom(), $urandom()});
  endtask

  // Mostly well-formed messages; some continue the previous keystream and a
  // few carry random start and last flags.
  task automatic random_message();
    int   len;
    int   kind;
    logic s;
    logic l;
    kind = $urandom_range(99);
    len = ($urandom_range(9) == 0) ? $urandom_range(100, 33) : $urandom_range(40, 1);
    for (int k = 0; k < len; k++) begin
      if (kind < 85) begin
        s = (k == 0) && (kind >= 10);
        l = (k == len - 1);
      end else begin
        s = ($urandom_range(7) == 0);
        l = 1'($urandom_range(1));
      end
      send_byte(8'($urandom_range(255)), s, l);
    end
  endtask

  initial begin
    logic [255:0] rand_key;
    bit           held;
    bit           paused;
    int           waited;
    held = 1'b0;
    paused = 1'b0;
    waited = 0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_msg_start = 1'b0;
    in_msg_last = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // No start since reset: the chain runs from the all-zero block.
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h5a, 1'b0, 1'b1);
    send_byte(8'hc3, 1'b0, 1'b0);

    drain_results();
    write_key('1);
    write_cfg(CFG_IDX_FIRST_UNUSED, {$urandom(), $urandom()});
    write_cfg(CFG_IDX_LAST, '1);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    send_byte(8'h7e, 1'b1, 1'b1);
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'h22, 1'b1, 1'b0);

    // A new key must not disturb the message already running.
    drain_results();
    for (int j = 0; j < 8; j++) rand_key[32*j +: 32] = $urandom();
    write_key(rand_key);
    send_byte(8'h33, 1'b0, 1'b0);
    send_byte(8'h44, 1'b0, 1'b1);
    send_byte(8'h55, 1'b1, 1'b1);

    drain_results();
    write_key('0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'ha5, 1'b0, 1'b1);

    while (sent_bytes < ITEM_TARGET) begin
      if (sent_bytes < ITEM_TARGET / 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 74;
      end else if (sent_bytes < 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 74;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (!held && sent_bytes >= 600) begin
        // The sender keeps offering requests while results pile up.
        held = 1'b1;
        hold_request = 1'b1;
        for (int k = 0; k < 48; k++) send_byte(8'($urandom_range(255)), k == 0, k == 47);
      end else if (!paused && sent_bytes >= 720) begin
        paused = 1'b1;
        drain_results();
      end else if ($urandom_range(11) == 0) begin
        random_config();
      end
      random_message();
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
